// ===== rtl/lpfa_pkg.sv =====
`timescale 1ns / 1ps

package lpfa_pkg;

    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 16;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PN_W       = ADDR_W - PAGE_SHIFT;
    localparam int SPAN_W     = PN_W + 1;
    localparam int DEPTH_W    = $clog2(MAX_PAGES + 1);
    localparam int IDX_W      = $clog2(MAX_PAGES);
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [ADDR_W-1:0] RANGE_START_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] RANGE_END_RST   = 32'h8800_0000;

    // register index, taken from paddr[2]
    localparam logic REG_RANGE_START = 1'b0;
    localparam logic REG_RANGE_END   = 1'b1;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_INIT  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NULL      = 3'd2,
        ST_UNALIGNED = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_BAD_END   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CK_ALLOC,
        CK_PUSH,
        CK_INIT,
        CK_REPORT
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_RDWAIT
    } bk_state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] free_addr;
    } request_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] page_addr;
        logic [CNT_W-1:0]  total_count;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  used_count;
    } result_t;

    typedef struct packed {
        cmd_kind_t          kind;
        status_t            status;
        logic [PN_W-1:0]    pn;
        logic [DEPTH_W-1:0] init_cnt;
        logic [PN_W-1:0]    init_base;
    } cmd_t;

endpackage

// ===== rtl/lifo_page_frame_allocator.sv =====
`timescale 1ns / 1ps

// LIFO page frame allocator. Requests (allocate, free, initialize) enter through a
// queue-style port and each gives exactly one result, in order, with the total, free
// and used page counts. A front stage checks frees and works out the page range of an
// initialize from range_start and range_end, then hands a command to a two-entry
// command queue; the back stage owns the free stack in a single-port memory of
// MAX_PAGES page numbers. Free, initialize and rejected requests are handled without
// leaving the idle state; an allocate also waits for the registered stack memory read.
// An initialize writes no memory: the fresh pages are kept as a base and a watermark,
// so no fill or clear pass is ever run. The user must write configuration over the APB
// port only while no request is in flight; the block itself does not enforce this.
module lifo_page_frame_allocator
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lpfa_pkg::PADDR_W-1:0] paddr,
    input  logic [lpfa_pkg::PDATA_W-1:0] pwdata,
    output logic [lpfa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  lpfa_pkg::request_t           request,
    output logic                         empty,
    input  logic                         pop,
    output lpfa_pkg::result_t            result
);

    lpfa_pkg::cmd_t front_cmd;
    lpfa_pkg::cmd_t queue_cmd;
    logic           queue_valid;
    logic           queue_pop;

    lpfa_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .request (request),
        .cmd     (front_cmd)
    );

    lpfa_cmd_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push),
        .wr_cmd (front_cmd),
        .full   (full),
        .rd_en  (queue_pop),
        .valid  (queue_valid),
        .rd_cmd (queue_cmd)
    );

    lpfa_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== rtl/lpfa_front.sv =====
`timescale 1ns / 1ps

module lpfa_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpfa_pkg::PADDR_W-1:0] paddr,
    input  logic [lpfa_pkg::PDATA_W-1:0] pwdata,
    output logic [lpfa_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  lpfa_pkg::request_t          request,
    output lpfa_pkg::cmd_t              cmd
);

    logic [lpfa_pkg::ADDR_W-1:0] range_start_reg;
    logic [lpfa_pkg::ADDR_W-1:0] range_end_reg;
    logic                        cfg_we;

    logic [lpfa_pkg::SPAN_W-1:0] sp;
    logic [lpfa_pkg::SPAN_W-1:0] ep;
    logic [lpfa_pkg::SPAN_W-1:0] span;
    logic [lpfa_pkg::SPAN_W-1:0] cnt;
    logic                        zero_first;
    logic                        too_many;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= lpfa_pkg::RANGE_START_RST;
            range_end_reg   <= lpfa_pkg::RANGE_END_RST;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == lpfa_pkg::REG_RANGE_START)
                range_start_reg <= pwdata;
            else
                range_end_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == lpfa_pkg::REG_RANGE_START) ? range_start_reg : range_end_reg;

    // page numbers of the rounded start and of the end
    always_comb
    begin
        sp = {1'b0, range_start_reg[lpfa_pkg::ADDR_W-1:lpfa_pkg::PAGE_SHIFT]}
             + lpfa_pkg::SPAN_W'(range_start_reg[lpfa_pkg::PAGE_SHIFT-1:0] != '0);
        ep = {1'b0, range_end_reg[lpfa_pkg::ADDR_W-1:lpfa_pkg::PAGE_SHIFT]};
        span = (ep > sp) ? (ep - sp) : '0;
        // page zero is never handed out
        zero_first = (sp == '0) && (span != '0);
        cnt = span - lpfa_pkg::SPAN_W'(zero_first);
        too_many = cnt > lpfa_pkg::SPAN_W'(lpfa_pkg::MAX_PAGES);
    end

    always_comb
    begin
        cmd = '0;
        cmd.kind   = lpfa_pkg::CK_REPORT;
        cmd.status = lpfa_pkg::ST_OK;
        cmd.pn     = request.free_addr[lpfa_pkg::ADDR_W-1:lpfa_pkg::PAGE_SHIFT];
        case (request.func)
            lpfa_pkg::FN_ALLOC:
            begin
                cmd.kind = lpfa_pkg::CK_ALLOC;
            end
            lpfa_pkg::FN_FREE:
            begin
                if (request.free_addr == '0)
                    cmd.status = lpfa_pkg::ST_NULL;
                else if (request.free_addr[lpfa_pkg::PAGE_SHIFT-1:0] != '0)
                    cmd.status = lpfa_pkg::ST_UNALIGNED;
                else
                    cmd.kind = lpfa_pkg::CK_PUSH;
            end
            lpfa_pkg::FN_INIT:
            begin
                if (range_end_reg[lpfa_pkg::PAGE_SHIFT-1:0] != '0)
                begin
                    cmd.status = lpfa_pkg::ST_BAD_END;
                end
                else
                begin
                    cmd.kind      = lpfa_pkg::CK_INIT;
                    cmd.status    = too_many ? lpfa_pkg::ST_OVERFLOW : lpfa_pkg::ST_OK;
                    cmd.init_cnt  = too_many ? lpfa_pkg::DEPTH_W'(lpfa_pkg::MAX_PAGES)
                                             : lpfa_pkg::DEPTH_W'(cnt);
                    cmd.init_base = zero_first ? lpfa_pkg::PN_W'(1)
                                               : sp[lpfa_pkg::PN_W-1:0];
                end
            end
            default:
            begin
                cmd.kind = lpfa_pkg::CK_REPORT;
            end
        endcase
    end

endmodule

// ===== rtl/lpfa_cmd_queue.sv =====
`timescale 1ns / 1ps

module lpfa_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  lpfa_pkg::cmd_t wr_cmd,
    output logic           full,
    input  logic           rd_en,
    output logic           valid,
    output lpfa_pkg::cmd_t rd_cmd
);

    lpfa_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_wr;
    logic           do_rd;

    assign full   = count_reg == 2'd2;
    assign valid  = count_reg != 2'd0;
    assign rd_cmd = slot_reg[rd_ptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

// ===== rtl/lpfa_back.sv =====
`timescale 1ns / 1ps

module lpfa_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  lpfa_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output logic              empty,
    input  logic              pop,
    output lpfa_pkg::result_t result
);

    logic [lpfa_pkg::PN_W-1:0] frame_mem [lpfa_pkg::MAX_PAGES];

    lpfa_pkg::bk_state_t          state_reg;
    lpfa_pkg::bk_state_t          state_next;
    logic [lpfa_pkg::DEPTH_W-1:0] depth_reg;
    logic [lpfa_pkg::DEPTH_W-1:0] depth_next;
    logic [lpfa_pkg::DEPTH_W-1:0] total_reg;
    logic [lpfa_pkg::DEPTH_W-1:0] total_next;
    // entries below low_reg still hold their init value and are not in memory
    logic [lpfa_pkg::DEPTH_W-1:0] low_reg;
    logic [lpfa_pkg::DEPTH_W-1:0] low_next;
    logic [lpfa_pkg::PN_W-1:0]    base_reg;
    logic [lpfa_pkg::PN_W-1:0]    base_next;
    logic [lpfa_pkg::PN_W-1:0]    rd_data_reg;
    logic                         formula_hit_reg;
    logic                         formula_hit_next;
    logic [lpfa_pkg::PN_W-1:0]    formula_reg;
    logic [lpfa_pkg::PN_W-1:0]    formula_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    lpfa_pkg::result_t            out_reg;
    lpfa_pkg::result_t            out_next;

    logic                         out_free;
    logic                         take;
    logic                         mem_we;
    logic                         mem_re;
    logic [lpfa_pkg::IDX_W-1:0]   mem_waddr;
    logic [lpfa_pkg::IDX_W-1:0]   mem_raddr;
    logic [lpfa_pkg::DEPTH_W-1:0] top_idx;
    logic [lpfa_pkg::DEPTH_W-1:0] used;
    logic [lpfa_pkg::PN_W-1:0]    popped_pn;

    assign out_free = !out_valid_reg || pop;
    assign take     = (state_reg == lpfa_pkg::BK_IDLE) && cmd_valid && out_free;
    assign cmd_pop  = take;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign top_idx  = depth_reg - lpfa_pkg::DEPTH_W'(1);
    assign popped_pn = formula_hit_reg ? formula_reg : rd_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpfa_pkg::BK_IDLE:
            begin
                if (take && cmd.kind == lpfa_pkg::CK_ALLOC && depth_reg != '0)
                    state_next = lpfa_pkg::BK_RDWAIT;
            end
            lpfa_pkg::BK_RDWAIT:
            begin
                if (out_free)
                    state_next = lpfa_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = lpfa_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        depth_next       = depth_reg;
        total_next       = total_reg;
        low_next         = low_reg;
        base_next        = base_reg;
        formula_hit_next = formula_hit_reg;
        formula_next     = formula_reg;
        out_valid_next   = out_valid_reg && !pop;
        out_next         = out_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = depth_reg[lpfa_pkg::IDX_W-1:0];
        mem_raddr        = top_idx[lpfa_pkg::IDX_W-1:0];
        out_next.status    = lpfa_pkg::ST_OK;
        out_next.page_addr = '0;

        case (state_reg)
            lpfa_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    case (cmd.kind)
                        lpfa_pkg::CK_ALLOC:
                        begin
                            if (depth_reg == '0)
                                out_next.status = lpfa_pkg::ST_EMPTY;
                            else
                            begin
                                depth_next       = top_idx;
                                mem_re           = 1'b1;
                                formula_hit_next = top_idx < low_reg;
                                formula_next     = base_reg + lpfa_pkg::PN_W'(top_idx);
                                if (top_idx < low_reg)
                                    low_next = top_idx;
                            end
                        end
                        lpfa_pkg::CK_PUSH:
                        begin
                            if (depth_reg >= lpfa_pkg::DEPTH_W'(lpfa_pkg::MAX_PAGES))
                                out_next.status = lpfa_pkg::ST_OVERFLOW;
                            else
                            begin
                                mem_we     = 1'b1;
                                depth_next = depth_reg + lpfa_pkg::DEPTH_W'(1);
                            end
                        end
                        lpfa_pkg::CK_INIT:
                        begin
                            out_next.status = cmd.status;
                            depth_next      = cmd.init_cnt;
                            total_next      = cmd.init_cnt;
                            low_next        = cmd.init_cnt;
                            base_next       = cmd.init_base;
                        end
                        default:
                        begin
                            out_next.status = cmd.status;
                        end
                    endcase
                    // an allocate shows up once the memory read is back
                    if (!(cmd.kind == lpfa_pkg::CK_ALLOC && depth_reg != '0))
                        out_valid_next = 1'b1;
                end
            end
            lpfa_pkg::BK_RDWAIT:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.page_addr = {popped_pn, {lpfa_pkg::PAGE_SHIFT{1'b0}}};
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase

        used = (total_next > depth_next) ? (total_next - depth_next) : '0;
        out_next.total_count = lpfa_pkg::CNT_W'(total_next);
        out_next.free_count  = lpfa_pkg::CNT_W'(depth_next);
        out_next.used_count  = lpfa_pkg::CNT_W'(used);
        if (!(out_valid_next && !(out_valid_reg && !pop)))
            out_next = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lpfa_pkg::BK_IDLE;
            depth_reg       <= '0;
            total_reg       <= '0;
            low_reg         <= '0;
            base_reg        <= '0;
            formula_hit_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            depth_reg       <= depth_next;
            total_reg       <= total_next;
            low_reg         <= low_next;
            base_reg        <= base_next;
            formula_hit_reg <= formula_hit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        formula_reg <= formula_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_waddr] <= cmd.pn;
        if (mem_re)
            rd_data_reg <= frame_mem[mem_raddr];
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= lpfa_pkg::DEPTH_W'(lpfa_pkg::MAX_PAGES)
        && total_reg <= lpfa_pkg::DEPTH_W'(lpfa_pkg::MAX_PAGES))
        else $error("stack depth or total beyond capacity");

    a_low_mark: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= depth_reg)
        else $error("init watermark above stack depth");

    a_rdwait_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpfa_pkg::BK_RDWAIT && out_free)
        |=> (state_reg == lpfa_pkg::BK_IDLE && out_valid_reg))
        else $error("allocate result not delivered after read");

    a_no_pop_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lpfa_pkg::BK_RDWAIT |-> !cmd_pop)
        else $error("command taken while a read is pending");

    a_alloc_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpfa_pkg::BK_IDLE && state_next == lpfa_pkg::BK_RDWAIT)
        |=> depth_reg == $past(depth_reg) - lpfa_pkg::DEPTH_W'(1))
        else $error("allocate did not pop one entry");

endmodule
